// ===== rtl/core/mcbar_pkg.sv =====
package mcbar_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int DATA_BITS_DEF    = 24;
  localparam int GAIN_PULSES      = 3;

  localparam int CMD_W     = 2;
  localparam int LEVELS_W  = 8;
  localparam int CH_W      = 3;
  localparam int READING_W = 24;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int WAIT_W    = 16;
  localparam int HALF_W    = 8;
  localparam int RETRY_W   = 8;

  localparam logic [HALF_W-1:0]  HALF_PERIOD_RST  = 8'd1;
  localparam logic [WAIT_W-1:0]  RETRY_WAIT_RST   = 16'd1000;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST  = 8'd10;
  localparam logic [WAIT_W-1:0]  POWER_SETTLE_RST = 16'd60;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_START      = 2'd1,
    CMD_POWER_DOWN = 2'd2,
    CMD_POWER_UP   = 2'd3
  } command_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD  = 2'd0,
    REG_RETRY_WAIT   = 2'd1,
    REG_RETRY_LIMIT  = 2'd2,
    REG_POWER_SETTLE = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_POLL   = 3'd1,
    PH_SHIFT  = 3'd2,
    PH_GAIN   = 3'd3,
    PH_SETTLE = 3'd4,
    PH_TOWAIT = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_TIMEOUT = 2'd1,
    OUT_READ    = 2'd2
  } out_kind_e;

  typedef struct packed {
    logic load_half;
    logic load_retry;
    logic load_settle;
    logic clr_wait;
    logic dec_wait;
    logic inc_retry;
    logic clr_retry;
    logic inc_bits;
    logic clr_bits;
    logic clr_shift;
    logic shift_en;
    logic clk_set;
    logic clk_clr;
    logic emit_timeout;
    logic emit_read;
    logic busy_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wait_zero;
    logic wait_le1;
    logic clk_high;
    logic lines_ready;
    logic retry_exhausted;
    logic shift_done;
    logic gain_done;
    logic settle_zero;
  } dp_stat_t;

endpackage

// ===== rtl/core/multi_channel_bridge_adc_reader_top.sv =====
// A result is registered and offered on the output in the cycle after its input transfer.
// Throughput: one tick per cycle while results are taken; a finished read issues
// NUM_CHANNELS results from the output stage, which holds off input until the last
// of them is taken. Bit timing is set by the tick counter, not the clock.
// Reset (rst_ni low, asynchronous): idle, clock line low, counters cleared,
// configuration back to its defaults.
module multi_channel_bridge_adc_reader_top #(
  parameter int NUM_CHANNELS = mcbar_pkg::NUM_CHANNELS_DEF,
  parameter int DATA_BITS    = mcbar_pkg::DATA_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] dout_levels
  input  logic [mcbar_pkg::LEVELS_W-1:0]   s_axis_tdata,
  // [1:0] command
  input  logic [mcbar_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] sck_level, [1] busy_res, [2] valid_res, [3] timed_out, [6:4] channel,
  // [30:7] reading, [31] zero
  output logic [mcbar_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mcbar_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcbar_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import mcbar_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      step;

  mcbar_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .command_i (s_axis_tuser),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mcbar_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .DATA_BITS    (DATA_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .step_o      (step),
    .dout_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

// ===== rtl/core/mcbar_ctrl.sv =====
module mcbar_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [mcbar_pkg::CMD_W-1:0]  command_i,
  input  mcbar_pkg::dp_stat_t          stat_i,
  output mcbar_pkg::ctrl_cmd_t         cmd_o
);
  import mcbar_pkg::*;

  phase_e phase_q, phase_d;
  command_e command;

  assign command = command_e'(command_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        unique case (command)
          CMD_START: begin
            if (stat_i.lines_ready) phase_d = PH_SHIFT;
            else if (stat_i.retry_exhausted) phase_d = PH_TOWAIT;
            else phase_d = PH_POLL;
          end
          CMD_POWER_DOWN, CMD_POWER_UP: begin
            phase_d = stat_i.settle_zero ? PH_IDLE : PH_SETTLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      PH_POLL: begin
        if (stat_i.wait_zero) begin
          if (stat_i.lines_ready) phase_d = PH_SHIFT;
          else if (stat_i.retry_exhausted) phase_d = PH_TOWAIT;
          else phase_d = PH_POLL;
        end
      end
      PH_TOWAIT: begin
        if (stat_i.wait_zero) phase_d = PH_IDLE;
      end
      PH_SHIFT: begin
        if (stat_i.wait_zero && stat_i.clk_high && stat_i.shift_done) phase_d = PH_GAIN;
      end
      PH_GAIN: begin
        if (stat_i.wait_zero && stat_i.clk_high && stat_i.gain_done) phase_d = PH_IDLE;
      end
      PH_SETTLE: begin
        if (stat_i.wait_le1) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.busy_next = (phase_d != PH_IDLE);
    unique case (phase_q)
      PH_IDLE: begin
        unique case (command)
          CMD_START: begin
            cmd_o.clr_shift = 1'b1;
            cmd_o.clr_bits  = 1'b1;
            if (stat_i.lines_ready) begin
              cmd_o.clk_clr   = 1'b1;
              cmd_o.load_half = 1'b1;
            end else begin
              cmd_o.load_retry = 1'b1;
              cmd_o.inc_retry  = !stat_i.retry_exhausted;
            end
          end
          CMD_POWER_DOWN: begin
            cmd_o.clk_set     = 1'b1;
            cmd_o.load_settle = 1'b1;
          end
          CMD_POWER_UP: begin
            cmd_o.clk_clr     = 1'b1;
            cmd_o.load_settle = 1'b1;
          end
          default: ;
        endcase
      end
      PH_POLL: begin
        if (!stat_i.wait_zero) begin
          cmd_o.dec_wait = 1'b1;
        end else if (stat_i.lines_ready) begin
          cmd_o.clk_clr   = 1'b1;
          cmd_o.load_half = 1'b1;
          cmd_o.clr_bits  = 1'b1;
        end else begin
          cmd_o.load_retry = 1'b1;
          cmd_o.inc_retry  = !stat_i.retry_exhausted;
        end
      end
      PH_TOWAIT: begin
        if (!stat_i.wait_zero) begin
          cmd_o.dec_wait = 1'b1;
        end else begin
          cmd_o.clr_retry    = 1'b1;
          cmd_o.emit_timeout = 1'b1;
        end
      end
      PH_SHIFT, PH_GAIN: begin
        if (!stat_i.wait_zero) begin
          cmd_o.dec_wait = 1'b1;
        end else if (!stat_i.clk_high) begin
          cmd_o.clk_set   = 1'b1;
          cmd_o.load_half = 1'b1;
        end else begin
          cmd_o.clk_clr   = 1'b1;
          cmd_o.load_half = 1'b1;
          cmd_o.inc_bits  = 1'b1;
          if (phase_q == PH_SHIFT) begin
            cmd_o.shift_en = 1'b1;
            cmd_o.clr_bits = stat_i.shift_done;
          end else if (stat_i.gain_done) begin
            // drop the reloaded half period: the read is finished
            cmd_o.load_half = 1'b0;
            cmd_o.clr_wait  = 1'b1;
            cmd_o.clr_bits  = 1'b1;
            cmd_o.clr_retry = 1'b1;
            cmd_o.emit_read = 1'b1;
          end
        end
      end
      PH_SETTLE: begin
        cmd_o.dec_wait = !stat_i.wait_zero;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/mcbar_dp.sv =====
module mcbar_dp #(
  parameter int NUM_CHANNELS = mcbar_pkg::NUM_CHANNELS_DEF,
  parameter int DATA_BITS    = mcbar_pkg::DATA_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  output logic                             step_o,
  input  logic [mcbar_pkg::LEVELS_W-1:0]   dout_i,
  input  mcbar_pkg::ctrl_cmd_t             cmd_i,
  output mcbar_pkg::dp_stat_t              stat_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mcbar_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcbar_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [mcbar_pkg::OUT_W-1:0]      m_data_o,
  output logic                             m_last_o
);
  import mcbar_pkg::*;

  localparam int BCW = $clog2(DATA_BITS + 1);
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [HALF_W-1:0]    half_q;
  logic [WAIT_W-1:0]    retry_wait_q;
  logic [RETRY_W-1:0]   retry_limit_q;
  logic [WAIT_W-1:0]    settle_q;

  logic [WAIT_W-1:0]    wait_q, wait_d;
  logic [BCW-1:0]       bits_q, bits_d;
  logic [BCW:0]         bits_inc;
  logic [RETRY_W-1:0]   retry_q, retry_d;
  logic                 clk_q, clk_d;
  logic [READING_W-1:0] sw_q [NUM_CHANNELS];

  logic                 pend_q, pend_d;
  logic [CHW-1:0]       idx_q, idx_d;
  out_kind_e            kind_q, kind_d;
  logic                 sck_q, busy_q;
  logic                 out_xfer, step;
  logic [CH_W-1:0]      ch_out;
  logic [READING_W-1:0] rd_out;
  cfg_reg_e             cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q        <= HALF_PERIOD_RST;
      retry_wait_q  <= RETRY_WAIT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
      settle_q      <= POWER_SETTLE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        REG_HALF_PERIOD:  half_q        <= cfg_data_i[HALF_W-1:0];
        REG_RETRY_WAIT:   retry_wait_q  <= cfg_data_i[WAIT_W-1:0];
        REG_RETRY_LIMIT:  retry_limit_q <= cfg_data_i[RETRY_W-1:0];
        REG_POWER_SETTLE: settle_q      <= cfg_data_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign bits_inc = {1'b0, bits_q} + 1'b1;

  assign stat_o.wait_zero       = (wait_q == '0);
  assign stat_o.wait_le1        = (wait_q[WAIT_W-1:1] == '0);
  assign stat_o.clk_high        = clk_q;
  assign stat_o.lines_ready     = (dout_i[NUM_CHANNELS-1:0] == '0);
  assign stat_o.retry_exhausted = (retry_q >= retry_limit_q);
  assign stat_o.shift_done      = (bits_inc >= (BCW+1)'(DATA_BITS));
  assign stat_o.gain_done       = (bits_inc >= (BCW+1)'(GAIN_PULSES));
  assign stat_o.settle_zero     = (settle_q == '0);

  always_comb begin
    wait_d = wait_q;
    if (cmd_i.load_half)        wait_d = {{(WAIT_W-HALF_W){1'b0}}, half_q};
    else if (cmd_i.load_retry)  wait_d = retry_wait_q;
    else if (cmd_i.load_settle) wait_d = settle_q;
    else if (cmd_i.clr_wait)    wait_d = '0;
    else if (cmd_i.dec_wait)    wait_d = wait_q - 1'b1;

    bits_d = bits_q;
    if (cmd_i.clr_bits)      bits_d = '0;
    else if (cmd_i.inc_bits) bits_d = bits_inc[BCW-1:0];

    retry_d = retry_q;
    if (cmd_i.clr_retry)      retry_d = '0;
    else if (cmd_i.inc_retry) retry_d = retry_q + 1'b1;

    clk_d = clk_q;
    if (cmd_i.clk_set)      clk_d = 1'b1;
    else if (cmd_i.clk_clr) clk_d = 1'b0;
  end

  // output stage: one result per tick, or one per channel on a finished read
  assign m_last_o = (kind_q != OUT_READ) || (idx_q == CHW'(NUM_CHANNELS - 1));
  assign out_xfer = pend_q && m_ready_i;
  assign s_ready_o = !pend_q || (m_ready_i && m_last_o);
  assign step      = s_valid_i && s_ready_o;
  assign step_o    = step;

  always_comb begin
    pend_d = pend_q;
    idx_d  = idx_q;
    kind_d = kind_q;
    if (out_xfer) begin
      if (m_last_o) pend_d = 1'b0;
      else          idx_d  = idx_q + 1'b1;
    end
    if (step) begin
      pend_d = 1'b1;
      idx_d  = '0;
      if (cmd_i.emit_read)         kind_d = OUT_READ;
      else if (cmd_i.emit_timeout) kind_d = OUT_TIMEOUT;
      else                         kind_d = OUT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= '0;
      bits_q  <= '0;
      retry_q <= '0;
      clk_q   <= 1'b0;
      sck_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else if (step) begin
      wait_q  <= wait_d;
      bits_q  <= bits_d;
      retry_q <= retry_d;
      clk_q   <= clk_d;
      sck_q   <= clk_d;
      busy_q  <= cmd_i.busy_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      idx_q  <= '0;
      kind_q <= OUT_NONE;
    end else begin
      pend_q <= pend_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
    end
  end

  for (genvar j = 0; j < NUM_CHANNELS; j++) begin : g_shift
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sw_q[j] <= '0;
      end else if (step && cmd_i.clr_shift) begin
        sw_q[j] <= '0;
      end else if (step && cmd_i.shift_en) begin
        sw_q[j] <= {sw_q[j][READING_W-2:0], dout_i[j]};
      end
    end
  end

  assign ch_out = (kind_q == OUT_READ) ? CH_W'(idx_q) : '0;
  assign rd_out = (kind_q == OUT_READ) ? sw_q[idx_q] : '0;

  assign m_valid_o = pend_q;
  assign m_data_o  = {1'b0, rd_out, ch_out, (kind_q == OUT_TIMEOUT),
                      (kind_q != OUT_NONE), busy_q, sck_q};

  a_read_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && kind_q == OUT_READ) |-> (idx_q <= CHW'(NUM_CHANNELS - 1)))
    else $error("result channel index past last channel");

  a_no_dec_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cmd_i.dec_wait) |-> (wait_q != '0))
    else $error("wait counter decremented at zero");

  a_dec_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cmd_i.dec_wait) |=> (wait_q == $past(wait_q) - 1'b1))
    else $error("wait counter did not step down by one");

  a_single_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !(cmd_i.emit_read && cmd_i.emit_timeout))
    else $error("read and timeout results issued on one tick");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cmd_i.emit_read) |=> !busy_q)
    else $error("finished read reported as busy");

endmodule
